/* hdl/sbsc_pkg.sv */
// ----------------------------------------------------------------------------
// sbsc_pkg
// Shared constants, types and helpers of the surface box size classifier.
// ----------------------------------------------------------------------------
package sbsc_pkg;

  // datapath sizes
  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 12;
  localparam int COUNT_WIDTH = 20;

  // fixed field widths
  localparam int SURF_W       = 16;
  localparam int OUT_EXT_W    = 20;
  localparam int MIN_POINTS_W = 20;
  localparam int LONGEST_W    = 19;
  localparam int ASPECT_W     = 8;
  localparam int ASPECT_FRAC  = 4;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_IDX_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_UPPER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_LOWER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_LIMIT  = CFG_IDX_W'(3);

  // configuration reset values
  localparam logic [MIN_POINTS_W-1:0] MIN_POINTS_RST    = MIN_POINTS_W'(200);
  localparam logic [LONGEST_W-1:0]    LONGEST_UPPER_RST = LONGEST_W'(2458);
  localparam logic [LONGEST_W-1:0]    LONGEST_LOWER_RST = LONGEST_W'(819);
  localparam logic [ASPECT_W-1:0]     ASPECT_LIMIT_RST  = ASPECT_W'(40);

  // start bounds of +-100 m, clamped to the coordinate range
  localparam longint COORD_MAX_L = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN_L = -COORD_MAX_L - 1;
  localparam longint START_L     = 100 * (64'sd1 <<< FRAC_BITS);
  localparam longint LO_START_L  = (START_L > COORD_MAX_L) ? COORD_MAX_L : START_L;
  localparam longint HI_START_L  = (-START_L < COORD_MIN_L) ? COORD_MIN_L : -START_L;
  localparam logic signed [COORD_WIDTH-1:0] LO_START = COORD_WIDTH'(LO_START_L);
  localparam logic signed [COORD_WIDTH-1:0] HI_START = COORD_WIDTH'(HI_START_L);
  localparam logic [COUNT_WIDTH-1:0]        COUNT_MAX = '1;

  // comparison widths
  localparam int CNT_CMP_W = (COUNT_WIDTH > MIN_POINTS_W) ? COUNT_WIDTH : MIN_POINTS_W;
  localparam int EXT_CMP_W = (COORD_WIDTH > LONGEST_W) ? COORD_WIDTH : LONGEST_W;
  localparam int PROD_W    = COORD_WIDTH + ASPECT_W;
  localparam int EXT_PAD_W = (COORD_WIDTH > OUT_EXT_W) ? COORD_WIDTH : OUT_EXT_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        extent_t;

  // one finished surface, as handed from front to back
  typedef struct packed {
    logic [SURF_W-1:0]      surf_num;
    logic [COUNT_WIDTH-1:0] count;
    coord_t                 x_lo;
    coord_t                 x_hi;
    coord_t                 y_lo;
    coord_t                 y_hi;
    coord_t                 z_lo;
    coord_t                 z_hi;
  } surf_rec_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [MIN_POINTS_W-1:0] min_points;
    logic [LONGEST_W-1:0]    longest_upper;
    logic [LONGEST_W-1:0]    longest_lower;
    logic [ASPECT_W-1:0]     aspect_limit;
  } cfg_t;

  // extent to result field width
  function automatic logic [OUT_EXT_W-1:0] to_out_ext(extent_t e);
    logic [EXT_PAD_W-1:0] pad;
    pad = EXT_PAD_W'(e);
    return OUT_EXT_W'(pad);
  endfunction

endpackage

/* hdl/sbsc_front.sv */
// ----------------------------------------------------------------------------
// sbsc_front
// Tracks the per-axis bounds and point count; closes a surface into a record.
// ----------------------------------------------------------------------------
module sbsc_front import sbsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  coord_t    in_x_coord,
  input  coord_t    in_y_coord,
  input  coord_t    in_z_coord,
  input  logic      in_end_of_surface,
  input  logic      q_full,
  output logic      q_push,
  output surf_rec_t q_rec
);

  coord_t                 lo_r  [3];
  coord_t                 hi_r  [3];
  coord_t                 lo_nxt[3];
  coord_t                 hi_nxt[3];
  coord_t                 pt    [3];
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [SURF_W-1:0]      surf_r;
  logic                   accept;

  assign pt[0] = in_x_coord;
  assign pt[1] = in_y_coord;
  assign pt[2] = in_z_coord;

  // hold off input while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // bounds including the current point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_nxt[a] = (pt[a] < lo_r[a]) ? pt[a] : lo_r[a];
      hi_nxt[a] = (pt[a] > hi_r[a]) ? pt[a] : hi_r[a];
    end
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_WIDTH'(1);
  end

  // record of the closing surface
  assign q_push = accept && in_end_of_surface;
  always_comb begin
    q_rec.surf_num = surf_r;
    q_rec.count    = count_nxt;
    q_rec.x_lo     = lo_nxt[0];
    q_rec.x_hi     = hi_nxt[0];
    q_rec.y_lo     = lo_nxt[1];
    q_rec.y_hi     = hi_nxt[1];
    q_rec.z_lo     = lo_nxt[2];
    q_rec.z_hi     = hi_nxt[2];
  end

  // running state; bounds and count restart and the surface number advances when a surface closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= LO_START;
        hi_r[a] <= HI_START;
      end
      count_r <= '0;
      surf_r  <= '0;
    end else if (accept) begin
      if (in_end_of_surface) begin
        for (int a = 0; a < 3; a++) begin
          lo_r[a] <= LO_START;
          hi_r[a] <= HI_START;
        end
        count_r <= '0;
        surf_r  <= surf_r + SURF_W'(1);
      end else begin
        for (int a = 0; a < 3; a++) begin
          lo_r[a] <= lo_nxt[a];
          hi_r[a] <= hi_nxt[a];
        end
        count_r <= count_nxt;
      end
    end
  end

endmodule

/* hdl/sbsc_queue.sv */
// ----------------------------------------------------------------------------
// sbsc_queue
// Small first-in first-out queue of surface records.
// ----------------------------------------------------------------------------
module sbsc_queue import sbsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  surf_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output surf_rec_t pop_rec
);

  surf_rec_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  fill_r;
  logic               do_push, do_pop;

  assign full    = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/sbsc_back.sv */
// ----------------------------------------------------------------------------
// sbsc_back
// Forms and sorts the box extents, applies the fit tests, drives results.
// ----------------------------------------------------------------------------
module sbsc_back import sbsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_empty,
  input  surf_rec_t             q_rec,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SURF_W-1:0]     out_surface_number,
  output logic                  out_size_fits,
  output logic [OUT_EXT_W-1:0]  out_longest_extent,
  output logic [OUT_EXT_W-1:0]  out_middle_extent,
  output logic [OUT_EXT_W-1:0]  out_shortest_extent
);

  // stage 1 registers
  logic              s1_valid_r;
  logic [SURF_W-1:0] s1_surf_r;
  logic              s1_cnt_ok_r;
  extent_t           s1_l1_r, s1_l2_r, s1_l3_r;

  // output registers
  logic              out_valid_r;
  logic [SURF_W-1:0] out_surf_r;
  logic              out_fits_r;
  extent_t           out_l1_r, out_l2_r, out_l3_r;

  logic    out_adv, s1_adv;
  extent_t ex, ey, ez;
  extent_t mn_ab, mx_ab, l1_nxt, l2_nxt, l3_nxt;
  logic    cnt_ok_nxt;
  logic [PROD_W-1:0] lhs, rhs;
  logic    too_long, too_short, too_flat, fits_nxt;

  // pipeline advance
  assign out_adv = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign q_pop   = !q_empty && s1_adv;

  // extents, wrapped to coordinate width, and a three-way sort
  always_comb begin
    ex = extent_t'(q_rec.x_hi - q_rec.x_lo);
    ey = extent_t'(q_rec.y_hi - q_rec.y_lo);
    ez = extent_t'(q_rec.z_hi - q_rec.z_lo);
    mn_ab  = (ex < ey) ? ex : ey;
    mx_ab  = (ex < ey) ? ey : ex;
    l1_nxt = (ez > mx_ab) ? ez : mx_ab;
    l3_nxt = (ez < mn_ab) ? ez : mn_ab;
    l2_nxt = (ez < mx_ab) ? ((ez > mn_ab) ? ez : mn_ab) : mx_ab;
    cnt_ok_nxt = CNT_CMP_W'(q_rec.count) >= CNT_CMP_W'(cfg.min_points);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_surf_r   <= q_rec.surf_num;
      s1_cnt_ok_r <= cnt_ok_nxt;
      s1_l1_r     <= l1_nxt;
      s1_l2_r     <= l2_nxt;
      s1_l3_r     <= l3_nxt;
    end
  end

  // length window and aspect test by multiplication
  always_comb begin
    too_long  = EXT_CMP_W'(s1_l1_r) > EXT_CMP_W'(cfg.longest_upper);
    too_short = EXT_CMP_W'(s1_l1_r) < EXT_CMP_W'(cfg.longest_lower);
    lhs       = PROD_W'(s1_l1_r) << ASPECT_FRAC;
    rhs       = PROD_W'(cfg.aspect_limit) * PROD_W'(s1_l2_r);
    too_flat  = lhs > rhs;
    fits_nxt  = s1_cnt_ok_r && !too_long && !too_short && !too_flat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_surf_r <= s1_surf_r;
      out_fits_r <= fits_nxt;
      out_l1_r   <= s1_l1_r;
      out_l2_r   <= s1_l2_r;
      out_l3_r   <= s1_l3_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_surface_number  = out_surf_r;
  assign out_size_fits       = out_fits_r;
  assign out_longest_extent  = to_out_ext(out_l1_r);
  assign out_middle_extent   = to_out_ext(out_l2_r);
  assign out_shortest_extent = to_out_ext(out_l3_r);

endmodule

/* hdl/surface_box_size_classifier_unit.sv */
// ----------------------------------------------------------------------------
// surface_box_size_classifier_unit
// Bounding box extent classifier for point surfaces: tracks min/max per axis,
// sorts the extents of each finished surface and judges whether it fits.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    x/y/z coordinate, end of surface
//   out      output     out_valid/out_stall  surface number, fit, 3 extents
//   cfg      input      cfg_wr_en            cfg_index, cfg_wr_data
//
// One point is taken every cycle while the record queue (4 entries) has room.
// A surface's result goes through the queue, the stage 1 registers and the
// output register; the back end takes one surface per cycle unless stalled.
// Synchronous active-low reset clears counters, queue and valids, and loads
// start bounds and configuration defaults. Output stall backs up through the
// two back stages into the queue; input stalls only once the queue is full.
// ----------------------------------------------------------------------------
module surface_box_size_classifier_unit import sbsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  coord_t                in_x_coord,
  input  coord_t                in_y_coord,
  input  coord_t                in_z_coord,
  input  logic                  in_end_of_surface,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SURF_W-1:0]     out_surface_number,
  output logic                  out_size_fits,
  output logic [OUT_EXT_W-1:0]  out_longest_extent,
  output logic [OUT_EXT_W-1:0]  out_middle_extent,
  output logic [OUT_EXT_W-1:0]  out_shortest_extent,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cfg_t      cfg_r;
  logic      q_full, q_push, q_empty, q_pop;
  surf_rec_t push_rec, pop_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_points    <= MIN_POINTS_RST;
      cfg_r.longest_upper <= LONGEST_UPPER_RST;
      cfg_r.longest_lower <= LONGEST_LOWER_RST;
      cfg_r.aspect_limit  <= ASPECT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_POINTS:    cfg_r.min_points    <= MIN_POINTS_W'(cfg_wr_data);
        CFG_LONGEST_UPPER: cfg_r.longest_upper <= LONGEST_W'(cfg_wr_data);
        CFG_LONGEST_LOWER: cfg_r.longest_lower <= LONGEST_W'(cfg_wr_data);
        CFG_ASPECT_LIMIT:  cfg_r.aspect_limit  <= ASPECT_W'(cfg_wr_data);
        default: ;
      endcase
    end
  end

  // front: bounds tracking
  sbsc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_x_coord        (in_x_coord),
    .in_y_coord        (in_y_coord),
    .in_z_coord        (in_z_coord),
    .in_end_of_surface (in_end_of_surface),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_rec             (push_rec)
  );

  // record queue
  sbsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (pop_rec)
  );

  // back: sort, test, result
  sbsc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_empty             (q_empty),
    .q_rec               (pop_rec),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_surface_number  (out_surface_number),
    .out_size_fits       (out_size_fits),
    .out_longest_extent  (out_longest_extent),
    .out_middle_extent   (out_middle_extent),
    .out_shortest_extent (out_shortest_extent)
  );

endmodule
